[rtl/aae_pkg.sv]
// Shared types and constants for the adaptive arithmetic encoder.
// No dependencies; the other files that use it refer to it by scoped names.
package aae_pkg;

	localparam int ALPHABET    = 256;
	localparam int COUNT_WIDTH = 24;
	localparam int RANGE_BITS  = 32;

	localparam int IDXW  = $clog2(ALPHABET);
	localparam int LW    = RANGE_BITS + 1;
	localparam int PW    = LW + COUNT_WIDTH;
	localparam int CNTW  = $clog2(PW + 1);
	localparam int FOLW  = 32;

	localparam logic [LW-1:0] Q_FULL  = LW'(1) << RANGE_BITS;
	localparam logic [LW-1:0] Q_ONE   = Q_FULL >> 2;
	localparam logic [LW-1:0] Q_TWO   = Q_FULL >> 1;
	localparam logic [LW-1:0] Q_THREE = Q_ONE + Q_TWO;

	localparam logic [COUNT_WIDTH-1:0] TOTAL_MAX  = {COUNT_WIDTH{1'b1}};
	localparam logic [COUNT_WIDTH-1:0] TOTAL_INIT = COUNT_WIDTH'(ALPHABET);
	localparam logic [FOLW-1:0]        SAT        = {FOLW{1'b1}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_ACC,
		ST_MINIT,
		ST_MUL,
		ST_DINIT,
		ST_DIV,
		ST_UPD,
		ST_REN,
		ST_FLUSH,
		ST_OVF,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic acc;
		logic minit;
		logic mstep;
		logic dinit;
		logic dstep;
		logic upd;
		logic ren;
		logic push_fin;
		logic push_ovf;
		logic push_last;
	} cmd_t;

	typedef struct packed {
		logic sym_oor;
		logic full;
		logic at_sym;
		logic mul_last;
		logic div_last;
		logic empty;
		logic dec;
		logic mid;
		logic iter_done;
		logic stg_valid;
		logic can_push;
	} status_t;

endpackage

[rtl/aae_in_if.sv]
// Input channel of the encoder: kind and symbol with valid/ready.
// Depends on nothing.
interface aae_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] symbol;

	modport source (output valid, output kind, output symbol, input ready);
	modport sink (input valid, input kind, input symbol, output ready);
endinterface

[rtl/aae_out_if.sv]
// Result channel of the encoder: decided bit, follow run, last and overflow.
// Depends on nothing.
interface aae_out_if;
	logic        valid;
	logic        ready;
	logic        lead_bit;
	logic [31:0] follow_count;
	logic        last;
	logic        overflow;

	modport source (output valid, output lead_bit, output follow_count, output last,
		output overflow, input ready);
	modport sink (input valid, input lead_bit, input follow_count, input last,
		input overflow, output ready);
endinterface

[rtl/adaptive_arith_encoder.sv]
// Top level of the adaptive order-0 arithmetic encoder.
// Depends on aae_pkg, aae_in_if, aae_out_if, aae_ctrl and aae_dp.
//
//   channel  dir  payload                                    handshake
//   sym_ch   in   kind, symbol                               valid/ready
//   res_ch   out  lead_bit, follow_count, last, overflow     valid/ready
//
// One item at a time. A symbol s is accepted, the counts of entries 0 to s are
// summed (one memory read per entry), the bounds go through the serial multiply
// and the restoring divide, the model is updated, the interval is renormalized
// one step at a time and the staged bit is flushed. A finish or full-count
// overflow item ends in a last result. Reset marks all counts as one.
// A full result register stalls the renormalization before it emits.
module adaptive_arith_encoder (
	input logic       clk,
	input logic       arst_n,
	aae_in_if.sink    sym_ch,
	aae_out_if.source res_ch
);

	aae_pkg::cmd_t    cmd;
	aae_pkg::status_t st;

	aae_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sym_ch.valid),
		.in_kind  (sym_ch.kind),
		.in_ready (sym_ch.ready),
		.st       (st),
		.cmd      (cmd)
	);

	aae_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_symbol  (sym_ch.symbol),
		.cmd        (cmd),
		.st         (st),
		.out_valid  (res_ch.valid),
		.out_ready  (res_ch.ready),
		.out_bit    (res_ch.lead_bit),
		.out_follow (res_ch.follow_count),
		.out_last   (res_ch.last),
		.out_ovf    (res_ch.overflow)
	);

endmodule

[rtl/aae_ctrl.sv]
// Sequencer of the encoder: walks one item through sum, multiply, divide,
// update and renormalization. Depends on aae_pkg.
module aae_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_kind,
	output logic              in_ready,
	input  aae_pkg::status_t  st,
	output aae_pkg::cmd_t     cmd
);

	aae_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aae_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			aae_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_kind) state_d = aae_pkg::ST_FIN;
					else if (st.sym_oor) state_d = aae_pkg::ST_IDLE;
					else if (st.full) state_d = aae_pkg::ST_OVF;
					else state_d = aae_pkg::ST_RD;
				end
			end
			aae_pkg::ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = aae_pkg::ST_ACC;
			end
			aae_pkg::ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = st.at_sym ? aae_pkg::ST_MINIT : aae_pkg::ST_RD;
			end
			aae_pkg::ST_MINIT: begin
				cmd.minit = 1'b1;
				state_d   = aae_pkg::ST_MUL;
			end
			aae_pkg::ST_MUL: begin
				cmd.mstep = 1'b1;
				if (st.mul_last) state_d = aae_pkg::ST_DINIT;
			end
			aae_pkg::ST_DINIT: begin
				cmd.dinit = 1'b1;
				state_d   = aae_pkg::ST_DIV;
			end
			aae_pkg::ST_DIV: begin
				cmd.dstep = 1'b1;
				if (st.div_last) state_d = aae_pkg::ST_UPD;
			end
			aae_pkg::ST_UPD: begin
				if (st.empty) begin
					state_d = aae_pkg::ST_OVF;
				end else begin
					cmd.upd = 1'b1;
					state_d = aae_pkg::ST_REN;
				end
			end
			aae_pkg::ST_REN: begin
				if (st.iter_done || !(st.dec || st.mid)) begin
					state_d = aae_pkg::ST_FLUSH;
				end else if (!(st.dec && st.stg_valid && !st.can_push)) begin
					cmd.ren = 1'b1;
				end
			end
			aae_pkg::ST_FLUSH: begin
				if (!st.stg_valid) begin
					state_d = aae_pkg::ST_IDLE;
				end else if (st.can_push) begin
					cmd.push_last = 1'b1;
					state_d       = aae_pkg::ST_IDLE;
				end
			end
			aae_pkg::ST_OVF: begin
				if (st.can_push) begin
					cmd.push_ovf = 1'b1;
					state_d      = aae_pkg::ST_IDLE;
				end
			end
			aae_pkg::ST_FIN: begin
				if (st.can_push) begin
					cmd.push_fin = 1'b1;
					state_d      = aae_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = aae_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/aae_dp.sv]
// Datapath of the encoder: count memory, serial multiplier and divider,
// interval registers and the result register. Depends on aae_pkg.
module aae_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [7:0]                in_symbol,
	input  aae_pkg::cmd_t             cmd,
	output aae_pkg::status_t          st,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      out_bit,
	output logic [aae_pkg::FOLW-1:0]  out_follow,
	output logic                      out_last,
	output logic                      out_ovf
);

	localparam int CW = aae_pkg::COUNT_WIDTH;
	localparam int LW = aae_pkg::LW;
	localparam int PW = aae_pkg::PW;

	logic [CW-1:0]                 mem_q [aae_pkg::ALPHABET];
	logic [aae_pkg::ALPHABET-1:0]  vld_q;
	logic [CW-1:0]                 rd_q;
	logic                          rdv_q;
	logic [CW-1:0]                 rd_val;

	logic [7:0]               sym_q;
	logic [aae_pkg::IDXW-1:0] idx_q;
	logic [CW-1:0]            cum_q, fr_q, total_q;
	logic [LW-1:0]            low_q, high_q;
	logic [aae_pkg::FOLW-1:0] pend_q;
	logic [aae_pkg::CNTW-1:0] cnt_q;

	logic [PW-1:0] mcand_q, plo_q, phi_q, dlo_q, dhi_q;
	logic [CW-1:0] mlo_q, mhi_q, rlo_q, rhi_q;

	logic                     stg_valid_q, stg_bit_q;
	logic [aae_pkg::FOLW-1:0] stg_follow_q;

	logic [LW-1:0]            lo_new, hi_new, off, w;
	logic [CW:0]              tlo, thi;
	logic                     ge_lo, ge_hi, upper;
	logic                     can_push, push, p_bit, p_last, p_ovf;
	logic [aae_pkg::FOLW-1:0] p_follow, pend_inc;

	assign rd_val = rdv_q ? rd_q : CW'(1);
	assign w      = high_q - low_q;
	assign lo_new = low_q + dlo_q[LW-1:0];
	assign hi_new = low_q + dhi_q[LW-1:0];
	assign upper  = low_q >= aae_pkg::Q_TWO;
	assign off    = upper ? aae_pkg::Q_TWO : '0;
	assign tlo    = {rlo_q, dlo_q[PW-1]};
	assign thi    = {rhi_q, dhi_q[PW-1]};
	assign ge_lo  = tlo >= {1'b0, total_q};
	assign ge_hi  = thi >= {1'b0, total_q};
	assign pend_inc = (pend_q == aae_pkg::SAT) ? aae_pkg::SAT : pend_q + 1'b1;
	assign can_push = !out_valid || out_ready;

	// status toward the sequencer
	always_comb begin
		st.sym_oor   = {1'b0, in_symbol} >= 9'(aae_pkg::ALPHABET);
		st.full      = total_q == aae_pkg::TOTAL_MAX;
		st.at_sym    = idx_q == sym_q[aae_pkg::IDXW-1:0];
		st.mul_last  = cnt_q == aae_pkg::CNTW'(CW - 1);
		st.div_last  = cnt_q == aae_pkg::CNTW'(PW - 1);
		st.empty     = hi_new <= lo_new;
		st.dec       = upper || (high_q <= aae_pkg::Q_TWO);
		st.mid       = !(low_q < aae_pkg::Q_ONE || high_q > aae_pkg::Q_THREE);
		st.iter_done = cnt_q == aae_pkg::CNTW'(aae_pkg::RANGE_BITS);
		st.stg_valid = stg_valid_q;
		st.can_push  = can_push;
	end

	// count memory: registered read, write on update
	always_ff @(posedge clk) begin
		if (cmd.rd) rd_q <= mem_q[idx_q];
		if (cmd.upd) mem_q[sym_q[aae_pkg::IDXW-1:0]] <= fr_q + 1'b1;
	end

	// entry valid bits and read valid; unwritten entries read as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rdv_q <= 1'b0;
		end else begin
			if (cmd.rd) rdv_q <= vld_q[idx_q];
			if (cmd.push_fin) vld_q <= '0;
			else if (cmd.upd) vld_q[sym_q[aae_pkg::IDXW-1:0]] <= 1'b1;
		end
	end

	// stream state: total, interval, pending run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= aae_pkg::TOTAL_INIT;
			low_q   <= '0;
			high_q  <= aae_pkg::Q_FULL;
			pend_q  <= '0;
		end else if (cmd.push_fin) begin
			total_q <= aae_pkg::TOTAL_INIT;
			low_q   <= '0;
			high_q  <= aae_pkg::Q_FULL;
			pend_q  <= '0;
		end else if (cmd.upd) begin
			total_q <= total_q + 1'b1;
			low_q   <= lo_new;
			high_q  <= hi_new;
		end else if (cmd.ren) begin
			if (st.dec) begin
				low_q  <= (low_q - off) << 1;
				high_q <= (high_q - off) << 1;
				pend_q <= '0;
			end else begin
				low_q  <= (low_q - aae_pkg::Q_ONE) << 1;
				high_q <= (high_q - aae_pkg::Q_ONE) << 1;
				pend_q <= pend_inc;
			end
		end
	end

	// step counter shared by multiply, divide and renormalization
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.minit || cmd.dinit || cmd.upd) begin
			cnt_q <= '0;
		end else if (cmd.mstep || cmd.dstep || cmd.ren) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// cumulative sum, serial multiply and restoring divide
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sym_q <= in_symbol;
			idx_q <= '0;
			cum_q <= '0;
		end
		if (cmd.acc) begin
			if (st.at_sym) begin
				fr_q <= rd_val;
			end else begin
				cum_q <= cum_q + rd_val;
				idx_q <= idx_q + 1'b1;
			end
		end
		if (cmd.minit) begin
			mcand_q <= PW'(w);
			mlo_q   <= cum_q;
			mhi_q   <= cum_q + fr_q;
			plo_q   <= '0;
			phi_q   <= '0;
		end
		if (cmd.mstep) begin
			if (mlo_q[0]) plo_q <= plo_q + mcand_q;
			if (mhi_q[0]) phi_q <= phi_q + mcand_q;
			mcand_q <= mcand_q << 1;
			mlo_q   <= mlo_q >> 1;
			mhi_q   <= mhi_q >> 1;
		end
		if (cmd.dinit) begin
			dlo_q <= plo_q;
			dhi_q <= phi_q;
			rlo_q <= '0;
			rhi_q <= '0;
		end
		if (cmd.dstep) begin
			rlo_q <= ge_lo ? CW'(tlo - {1'b0, total_q}) : tlo[CW-1:0];
			rhi_q <= ge_hi ? CW'(thi - {1'b0, total_q}) : thi[CW-1:0];
			dlo_q <= {dlo_q[PW-2:0], ge_lo};
			dhi_q <= {dhi_q[PW-2:0], ge_hi};
		end
	end

	// staged decided bit, held until the next one shows whether it is last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_valid_q <= 1'b0;
		end else if (cmd.upd || cmd.push_last) begin
			stg_valid_q <= 1'b0;
		end else if (cmd.ren && st.dec) begin
			stg_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ren && st.dec) begin
			stg_bit_q    <= upper;
			stg_follow_q <= pend_q;
		end
	end

	// select the item to push into the result register
	always_comb begin
		push     = 1'b0;
		p_bit    = stg_bit_q;
		p_follow = stg_follow_q;
		p_last   = 1'b0;
		p_ovf    = 1'b0;
		if (cmd.push_fin) begin
			push     = 1'b1;
			p_bit    = !(low_q <= aae_pkg::Q_ONE && high_q >= aae_pkg::Q_TWO);
			p_follow = pend_inc;
			p_last   = 1'b1;
		end else if (cmd.push_ovf) begin
			push     = 1'b1;
			p_bit    = 1'b0;
			p_follow = '0;
			p_last   = 1'b1;
			p_ovf    = 1'b1;
		end else if (cmd.push_last) begin
			push   = 1'b1;
			p_last = 1'b1;
		end else if (cmd.ren && st.dec && stg_valid_q) begin
			push = 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (push) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_bit    <= p_bit;
			out_follow <= p_follow;
			out_last   <= p_last;
			out_ovf    <= p_ovf;
		end
	end

endmodule
